>>> design/vva_pkg.sv
// Shared types, widths and codes for the fixed-point vector ALU.
`timescale 1ns / 1ps
package vva_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int LANES     = 4;
	localparam int ROOT_BITS = WORD_BITS + 1;
	localparam int RAD_BITS  = 2 * WORD_BITS + 2;
	localparam int DIV_BITS  = WORD_BITS + FRAC_BITS + 2;
	localparam int DIV_STEPS = FRAC_BITS + 1;

	localparam logic [3:0] FN_NORM4 = 4'd0;
	localparam logic [3:0] FN_NORM3 = 4'd1;
	localparam logic [3:0] FN_LEN   = 4'd2;
	localparam logic [3:0] FN_LENSQ = 4'd3;
	localparam logic [3:0] FN_DOT   = 4'd4;
	localparam logic [3:0] FN_ADD   = 4'd5;
	localparam logic [3:0] FN_SUB   = 4'd6;
	localparam logic [3:0] FN_MUL   = 4'd7;
	localparam logic [3:0] FN_SCALE = 4'd8;
	localparam logic [3:0] FN_MIN   = 4'd9;
	localparam logic [3:0] FN_MAX   = 4'd10;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic  sat;
		word_t val;
	} rsat_t;

	typedef struct packed {
		logic signed [2*WORD_BITS-1:0] prod;
		word_t                         elem;
		logic                          esat;
		word_t                         mag;
		logic                          neg;
	} lane_t;

	typedef struct packed {
		logic [3:0]              func;
		word_t [LANES-1:0]       r;
		word_t                   rs;
		logic                    sat;
		logic                    zero;
		word_t [LANES-1:0]       mag;
		logic [LANES-1:0]        neg;
	} pay_t;

	// round to nearest (ties up), drop fraction, clamp to word range
	function automatic rsat_t rnd_sat(input logic signed [RAD_BITS-1:0] v);
		logic signed [RAD_BITS-1:0] t;
		rsat_t res;
		t = v + $signed(RAD_BITS'(1) << (FRAC_BITS - 1));
		t = t >>> FRAC_BITS;
		if ((&t[RAD_BITS-1:WORD_BITS-1]) || !(|t[RAD_BITS-1:WORD_BITS-1])) begin
			res.sat = 1'b0;
			res.val = t[WORD_BITS-1:0];
		end else begin
			res.sat = 1'b1;
			res.val = t[RAD_BITS-1] ? WMIN : WMAX;
		end
		return res;
	endfunction

endpackage

>>> design/vva_lane.sv
// One component lane: multiplier, elementwise add/sub/min/max, magnitude.
`timescale 1ns / 1ps
module vva_lane (
	input  logic          clk,
	input  logic [3:0]    func,
	input  vva_pkg::word_t a,
	input  vva_pkg::word_t b,
	input  vva_pkg::word_t sc,
	output vva_pkg::lane_t q
);
	import vva_pkg::*;

	word_t                         op2;
	logic signed [WORD_BITS:0]     s;
	lane_t                         ln;
	lane_t                         lane_s1;

	always_comb begin
		if (func inside {FN_SCALE})
			op2 = sc;
		else if (func inside {FN_DOT, FN_MUL})
			op2 = b;
		else
			op2 = a;

		if (func == FN_SUB)
			s = $signed({a[WORD_BITS-1], a}) - $signed({b[WORD_BITS-1], b});
		else
			s = $signed({a[WORD_BITS-1], a}) + $signed({b[WORD_BITS-1], b});

		ln.prod = $signed(a) * $signed(op2);
		ln.esat = 1'b0;
		case (func)
			FN_ADD, FN_SUB: begin
				ln.esat = s[WORD_BITS] != s[WORD_BITS-1];
				ln.elem = ln.esat ? (s[WORD_BITS] ? WMIN : WMAX) : s[WORD_BITS-1:0];
			end
			FN_MIN: ln.elem = ($signed(a) < $signed(b)) ? a : b;
			FN_MAX: ln.elem = ($signed(a) > $signed(b)) ? a : b;
			default: ln.elem = '0;
		endcase
		ln.neg = a[WORD_BITS-1];
		ln.mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
	end

	always_ff @(posedge clk) begin
		lane_s1 <= ln;
	end

	assign q = lane_s1;

endmodule

>>> design/vva_merge.sv
// Merge stage: sums lane products, rounds, picks per-op results.
`timescale 1ns / 1ps
module vva_merge (
	input  logic                            clk,
	input  logic [3:0]                      func,
	input  vva_pkg::lane_t [vva_pkg::LANES-1:0] ln,
	output logic [vva_pkg::RAD_BITS-1:0]    rad,
	output vva_pkg::pay_t                   pay
);
	import vva_pkg::*;

	logic [RAD_BITS-1:0]        sq;
	logic signed [RAD_BITS-1:0] dot;
	logic signed [RAD_BITS-1:0] pe [LANES];
	rsat_t                      mr [LANES];
	rsat_t                      sqr;
	rsat_t                      dtr;
	pay_t                       p;
	logic [RAD_BITS-1:0]        rad_s2;
	pay_t                       pay_s2;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pe[i] = {{(RAD_BITS-2*WORD_BITS){ln[i].prod[2*WORD_BITS-1]}}, ln[i].prod};
			mr[i] = rnd_sat(pe[i]);
		end
		// squares are nonnegative, so the signed extension is also the unsigned value
		sq = pe[0] + pe[1] + pe[2] + ((func == FN_NORM4) ? pe[3] : '0);
		dot = pe[0] + pe[1] + pe[2];
		sqr = rnd_sat($signed(sq));
		dtr = rnd_sat(dot);

		p.func = func;
		p.r    = '0;
		p.rs   = '0;
		p.sat  = 1'b0;
		p.zero = (sq == '0);
		for (int i = 0; i < LANES; i++) begin
			p.mag[i] = ln[i].mag;
			p.neg[i] = ln[i].neg;
		end
		case (func)
			FN_ADD, FN_SUB, FN_MIN, FN_MAX: begin
				for (int i = 0; i < 3; i++) begin
					p.r[i] = ln[i].elem;
					p.sat  = p.sat | ln[i].esat;
				end
			end
			FN_MUL, FN_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					p.r[i] = mr[i].val;
					p.sat  = p.sat | mr[i].sat;
				end
			end
			FN_LENSQ: begin
				p.rs  = sqr.val;
				p.sat = sqr.sat;
			end
			FN_DOT: begin
				p.rs  = dtr.val;
				p.sat = dtr.sat;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rad_s2 <= sq;
		pay_s2 <= p;
	end

	assign rad = rad_s2;
	assign pay = pay_s2;

endmodule

>>> design/vva_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module vva_sqrt (
	input  logic                           clk,
	input  logic [vva_pkg::RAD_BITS-1:0]   rad,
	output logic [vva_pkg::ROOT_BITS-1:0]  root,
	output logic [vva_pkg::RAD_BITS-1:0]   rem
);
	import vva_pkg::*;

	logic [RAD_BITS-1:0]  rem_q  [1:ROOT_BITS];
	logic [ROOT_BITS-1:0] root_q [1:ROOT_BITS];

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
		localparam int B = ROOT_BITS - 1 - k;
		logic [RAD_BITS-1:0]  rin;
		logic [ROOT_BITS-1:0] qin;
		logic [RAD_BITS-1:0]  trial;

		if (k == 0) begin : g_first
			assign rin = rad;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_q[k];
			assign qin = root_q[k];
		end

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign trial = (RAD_BITS'(qin) << (B + 1)) | (RAD_BITS'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (rin >= trial) begin
				rem_q[k+1]  <= rin - trial;
				root_q[k+1] <= qin | (ROOT_BITS'(1) << B);
			end else begin
				rem_q[k+1]  <= rin;
				root_q[k+1] <= qin;
			end
		end
	end

	assign root = root_q[ROOT_BITS];
	assign rem  = rem_q[ROOT_BITS];

endmodule

>>> design/vva_div.sv
// Pipelined restoring divider for one normalize lane, signed result.
`timescale 1ns / 1ps
module vva_div (
	input  logic                           clk,
	input  logic [vva_pkg::DIV_BITS-1:0]   num,
	input  logic [vva_pkg::ROOT_BITS-1:0]  den,
	input  logic                           neg,
	output vva_pkg::word_t                 quo
);
	import vva_pkg::*;

	logic [DIV_BITS-1:0]  rem_q [1:DIV_STEPS];
	logic [DIV_STEPS-1:0] q_q   [1:DIV_STEPS];
	logic [ROOT_BITS-1:0] den_q [1:DIV_STEPS];
	logic                 neg_q [1:DIV_STEPS];
	word_t                qw;

	// quotient never exceeds 2^FRAC_BITS, so FRAC_BITS+1 bits suffice
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int B = FRAC_BITS - k;
		logic [DIV_BITS-1:0]  rin;
		logic [DIV_STEPS-1:0] qin;
		logic [ROOT_BITS-1:0] din;
		logic                 nin;
		logic [DIV_BITS-1:0]  trial;

		if (k == 0) begin : g_first
			assign rin = num;
			assign qin = '0;
			assign din = den;
			assign nin = neg;
		end else begin : g_next
			assign rin = rem_q[k];
			assign qin = q_q[k];
			assign din = den_q[k];
			assign nin = neg_q[k];
		end

		assign trial = DIV_BITS'(din) << B;

		always_ff @(posedge clk) begin
			den_q[k+1] <= din;
			neg_q[k+1] <= nin;
			if (rin >= trial) begin
				rem_q[k+1] <= rin - trial;
				q_q[k+1]   <= qin | (DIV_STEPS'(1) << B);
			end else begin
				rem_q[k+1] <= rin;
				q_q[k+1]   <= qin;
			end
		end
	end

	assign qw  = WORD_BITS'(q_q[DIV_STEPS]);
	assign quo = neg_q[DIV_STEPS] ? (~qw + 1'b1) : qw;

endmodule

>>> design/vector3_vector4_alu_core.sv
// Top level of the fixed-point vector ALU: lanes, merge, square root, dividers.
`timescale 1ns / 1ps
// Signed Q16.16 vector ALU, fully pipelined: one item is taken every cycle and
// its result is marked by a one-cycle done pulse. Every operation runs the
// same path so results leave in order; the path's length is set by the
// 33-stage square root and the 17-stage divide of the normalize path.
// busy is always low, and results are not held, so the receiver must take each
// one in the cycle it is shown.
module vector3_vector4_alu_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [3:0]     func,
	input  vva_pkg::word_t a_x,
	input  vva_pkg::word_t a_y,
	input  vva_pkg::word_t a_z,
	input  vva_pkg::word_t a_w,
	input  vva_pkg::word_t b_x,
	input  vva_pkg::word_t b_y,
	input  vva_pkg::word_t b_z,
	input  vva_pkg::word_t scale,
	output logic           done,
	output vva_pkg::word_t r_x,
	output vva_pkg::word_t r_y,
	output vva_pkg::word_t r_z,
	output vva_pkg::word_t r_w,
	output vva_pkg::word_t r_scalar,
	output logic [1:0]     status
);
	import vva_pkg::*;

	localparam int LAT = ROOT_BITS + FRAC_BITS + 5;

	word_t                av [LANES];
	word_t                bv [LANES];
	lane_t [LANES-1:0]    lq;
	logic [3:0]           func_s1;
	logic [RAD_BITS-1:0]  rad;
	pay_t                 pay;
	pay_t                 sq_q [ROOT_BITS];
	logic [ROOT_BITS-1:0] root;
	logic [RAD_BITS-1:0]  rem;
	logic [ROOT_BITS-1:0] len;
	pay_t                 p3;
	logic [ROOT_BITS-1:0] len_s3;
	pay_t                 pay_s3;
	pay_t                 dv_q [DIV_STEPS];
	word_t                quo [LANES];
	pay_t                 pf;
	word_t [LANES-1:0]    rv;
	logic [1:0]           st;
	logic [LAT-1:0]       vld_q;
	word_t [LANES-1:0]    r_q;
	word_t                rs_q;
	logic [1:0]           st_q;

	assign busy = 1'b0;

	assign av[0] = a_x;
	assign av[1] = a_y;
	assign av[2] = a_z;
	assign av[3] = a_w;
	assign bv[0] = b_x;
	assign bv[1] = b_y;
	assign bv[2] = b_z;
	assign bv[3] = '0;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		vva_lane u_lane (
			.clk  (clk),
			.func (func),
			.a    (av[i]),
			.b    (bv[i]),
			.sc   (scale),
			.q    (lq[i])
		);
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
	end

	vva_merge u_merge (
		.clk  (clk),
		.func (func_s1),
		.ln   (lq),
		.rad  (rad),
		.pay  (pay)
	);

	vva_sqrt u_sqrt (
		.clk  (clk),
		.rad  (rad),
		.root (root),
		.rem  (rem)
	);

	always_ff @(posedge clk) begin
		sq_q[0] <= pay;
		for (int k = 1; k < ROOT_BITS; k++)
			sq_q[k] <= sq_q[k-1];
	end

	// round root to nearest, fill in the length result
	always_comb begin
		len = root + ROOT_BITS'(rem > RAD_BITS'(root));
		p3  = sq_q[ROOT_BITS-1];
		if (p3.func == FN_LEN) begin
			if (|len[ROOT_BITS-1:WORD_BITS-1]) begin
				p3.rs  = WMAX;
				p3.sat = 1'b1;
			end else begin
				p3.rs = len[WORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		len_s3 <= len;
		pay_s3 <= p3;
	end

	for (genvar i = 0; i < LANES; i++) begin : g_div
		vva_div u_div (
			.clk (clk),
			.num ((DIV_BITS'(pay_s3.mag[i]) << FRAC_BITS) + DIV_BITS'(len_s3 >> 1)),
			.den (len_s3),
			.neg (pay_s3.neg[i]),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		dv_q[0] <= pay_s3;
		for (int k = 1; k < DIV_STEPS; k++)
			dv_q[k] <= dv_q[k-1];
	end

	always_comb begin
		pf = dv_q[DIV_STEPS-1];
		rv = pf.r;
		st = pf.sat ? ST_SAT : ST_OK;
		if (pf.func inside {FN_NORM4, FN_NORM3}) begin
			rv = '0;
			if (pf.zero) begin
				st = ST_ZERO;
			end else begin
				st = ST_OK;
				for (int i = 0; i < 3; i++)
					rv[i] = quo[i];
				if (pf.func == FN_NORM4)
					rv[3] = quo[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		r_q  <= rv;
		rs_q <= pf.rs;
		st_q <= st;
	end

	assign done     = vld_q[LAT-1];
	assign r_x      = r_q[0];
	assign r_y      = r_q[1];
	assign r_z      = r_q[2];
	assign r_w      = r_q[3];
	assign r_scalar = rs_q;
	assign status   = st_q;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item did not complete after fixed latency");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ZERO) |-> (r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0))
		else $error("zero-length normalize returned nonzero vector");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
		else $error("status code out of range");
`endif

endmodule
